// ----- rtl/tlst_pkg.sv -----
// ----------------------------------------------------------------------------
// TSCH link schedule table: shared definitions
// Operation and status codes, the link record kept in memory, the state
// type of the control sequencer and the default table sizes.
// ----------------------------------------------------------------------------
package tlst_pkg;

    // Default table sizes
    localparam int DEF_MAX_LINKS  = 32;
    localparam int DEF_MAX_FRAMES = 4;

    // Field widths
    localparam int ASN_W = 40;

    // Operation codes
    localparam logic [2:0] OP_ADD_FRAME = 3'd0;
    localparam logic [2:0] OP_REM_FRAME = 3'd1;
    localparam logic [2:0] OP_ADD_LINK  = 3'd2;
    localparam logic [2:0] OP_REM_LINK  = 3'd3;
    localparam logic [2:0] OP_QUERY     = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // One link as held in the link memory
    typedef struct packed {
        logic [15:0] slot;
        logic [15:0] chan;
        logic [15:0] id;
        logic [3:0]  opt;
        logic [1:0]  kind;
        logic [63:0] addr;
    } t_link;

    // Control sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_COMPACT,
        S_ADD,
        S_QFRAME,
        S_QDIV,
        S_QSCAN,
        S_QEND,
        S_DONE
    } t_state;

endpackage

// ----- rtl/tlst_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tlst_div.sv -----
// ----------------------------------------------------------------------------
// Slot number remainder unit
// Restoring division of the absolute slot number by a slotframe size, one
// dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module tlst_div
    import tlst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ASN_W-1:0] i_dividend,
    input  logic [15:0]      i_divisor,
    output logic             o_done,
    output logic [15:0]      o_rem
);

    localparam int CNT_W = $clog2(ASN_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ASN_W-1:0] r_dv;
    logic [15:0]      r_dsr;
    logic [15:0]      r_rem;
    logic [16:0]      trial;
    logic             fits;
    logic [16:0]      diff;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_dv[ASN_W-1]};
        fits  = (trial >= {1'b0, r_dsr});
        diff  = trial - {1'b0, r_dsr};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ASN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dv  <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dv  <= {r_dv[ASN_W-2:0], 1'b0};
            r_rem <= fits ? diff[15:0] : trial[15:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/tsch_link_schedule_table_top.sv -----
// ----------------------------------------------------------------------------
// TSCH link schedule table
// Holds slotframes and links, adds and removes them and finds the next
// active link for an absolute slot number.
//
//   Channel   | Handshake           | Payload
//   ----------+---------------------+-------------------------------------
//   command   | i_valid / o_ready   | i_operation and the link fields
//   result    | o_valid / i_ready   | o_status, o_link_id, chosen link
//
// Adding a slotframe works on the slotframe table alone; removing one also
// rewrites the order memory. Link operations scan the link memory once and,
// on removal, rewrite the order memory. A query runs, per slotframe, the
// remainder unit and then a pass through the order and link memories.
// Reset is synchronous and needs no clearing pass. A stalled result is held
// in the output register while the next command is taken.
// ----------------------------------------------------------------------------
module tsch_link_schedule_table_top
    import tlst_pkg::*;
#(
    parameter int MAX_LINKS  = DEF_MAX_LINKS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_frame_handle,
    input  logic [15:0] i_frame_size,
    input  logic [3:0]  i_option_bits,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_peer_address,
    input  logic [15:0] i_slot_index,
    input  logic [15:0] i_channel_shift,
    input  logic [39:0] i_absolute_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_link_id,
    output logic [15:0] o_slots_until,
    output logic [15:0] o_chosen_frame,
    output logic [15:0] o_chosen_slot,
    output logic [15:0] o_chosen_channel,
    output logic [3:0]  o_chosen_options,
    output logic [1:0]  o_chosen_kind,
    output logic [63:0] o_chosen_address,
    output logic        o_backup_found,
    output logic [15:0] o_backup_id
);

    localparam int LW  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CW  = $clog2(MAX_LINKS + 1);
    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam int LINK_W = $bits(t_link);

    t_state r_state, n_state;

    // Latched command
    logic [2:0]       r_op;
    logic [15:0]      r_handle, r_size, r_slot, r_chan;
    logic [3:0]       r_opt;
    logic [1:0]       r_kind;
    logic [63:0]      r_addr;
    logic [ASN_W-1:0] r_asn;

    // Slotframe table
    logic             r_fvalid  [MAX_FRAMES];
    logic [15:0]      r_fhandle [MAX_FRAMES];
    logic [15:0]      r_fsize   [MAX_FRAMES];
    logic [FW-1:0]    r_forder  [MAX_FRAMES];
    logic [FCW-1:0]   r_fcount;

    // Link bookkeeping beside the memories
    logic [MAX_LINKS-1:0] r_lvalid;
    logic [FW-1:0]    r_lframe [MAX_LINKS];
    logic [CW-1:0]    r_lcount;
    logic [15:0]      r_next_id;

    // Walk counters and pipeline flags
    logic [CW-1:0]    r_i, r_j;
    logic             r_pv1, r_pv2;
    logic [LW-1:0]    r_l2;
    logic [FCW-1:0]   r_fi;
    logic [FW-1:0]    r_cf, r_fsel;
    logic [15:0]      r_now;

    // Best and backup link
    logic             r_bfound, r_kfound;
    logic [15:0]      r_bt, r_bid, r_bslot, r_bchan, r_bfh, r_kid;
    logic [3:0]       r_bopt;
    logic [1:0]       r_bkind;
    logic [63:0]      r_baddr;

    // Result under construction and output register
    logic [2:0]       r_status;
    logic [15:0]      r_rid;
    logic             r_ovalid;
    logic [2:0]       r_ostatus;
    logic [15:0]      r_olink, r_ountil, r_oframe, r_oslot, r_ochan, r_okid;
    logic [3:0]       r_oopt;
    logic [1:0]       r_okind;
    logic [63:0]      r_oaddr;
    logic             r_okfound;

    // Memory ports
    logic             seq_we;
    logic [LW-1:0]    seq_waddr, seq_wdata, seq_raddr, seq_q;
    logic             lnk_we;
    logic [LW-1:0]    lnk_waddr, lnk_raddr;
    t_link            lnk_wdata, l_q;
    logic [LINK_W-1:0] lnk_rdata;

    logic             div_start, div_done;
    logic [15:0]      div_rem;

    // Lookup and status signals
    logic             accept, out_load;
    logic             f_hit, f_free_ok, l_free_ok;
    logic [FW-1:0]    f_idx, f_free;
    logic [LW-1:0]    l_free, idx_i;
    logic [FW-1:0]    fo_new [MAX_FRAMES];
    logic [FCW-1:0]   fo_cnt;
    logic             issue_links, issue_seq, q_more;
    logic             find_match, find_end, cmp_keep, cmp_end, qscan_end;
    logic [15:0]      fsz, slot_gap;
    logic             take_first, tie, nb;

    assign accept   = i_valid && o_ready;
    assign out_load = !r_ovalid || i_ready;
    assign idx_i    = r_i[LW-1:0];
    assign l_q      = t_link'(lnk_rdata);

    // Slotframe lookup by handle and lowest free slotframe entry
    always_comb begin
        f_hit     = 1'b0;
        f_idx     = '0;
        f_free_ok = 1'b0;
        f_free    = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (r_fvalid[k] && r_fhandle[k] == r_handle) begin
                f_hit = 1'b1;
                f_idx = FW'(k);
            end
        end
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (!r_fvalid[k]) begin
                f_free_ok = 1'b1;
                f_free    = FW'(k);
            end
        end
    end

    // Lowest free link entry
    always_comb begin
        l_free_ok = 1'b0;
        l_free    = '0;
        for (int k = MAX_LINKS - 1; k >= 0; k--) begin
            if (!r_lvalid[k]) begin
                l_free_ok = 1'b1;
                l_free    = LW'(k);
            end
        end
    end

    // Slotframe order with the looked-up slotframe taken out
    always_comb begin
        logic [FCW-1:0] j;
        j = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            fo_new[k] = '0;
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (FCW'(k) < r_fcount && r_forder[k] != f_idx) begin
                fo_new[j[FW-1:0]] = r_forder[k];
                j = j + 1'b1;
            end
        end
        fo_cnt = j;
    end

    // Walk conditions
    always_comb begin
        issue_links = (r_i < CW'(MAX_LINKS));
        issue_seq   = (r_i < r_lcount);
        q_more      = (r_fi < r_fcount);
        find_match  = r_pv1 && l_q.slot == r_slot && l_q.chan == r_chan;
        find_end    = !issue_links && !r_pv1;
        cmp_keep    = r_pv1 && r_lvalid[seq_q];
        cmp_end     = !issue_seq && !r_pv1;
        qscan_end   = !issue_seq && !r_pv1 && !r_pv2;
    end

    // Distance to a link and the tie rules against the current best
    always_comb begin
        fsz  = r_fsize[r_cf];
        slot_gap = (l_q.slot > r_now) ? (l_q.slot - r_now) : (fsz + l_q.slot - r_now);
        take_first = !r_bfound || slot_gap < r_bt;
        tie  = r_bfound && slot_gap == r_bt && l_q.chan != r_bchan;
        nb   = (r_bopt[0] == l_q.opt[0]) ? (r_fhandle[r_cf] < r_bfh) : l_q.opt[0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ADD_FRAME: n_state = S_DONE;
                    OP_REM_FRAME: n_state = f_hit ? S_COMPACT : S_DONE;
                    OP_ADD_LINK,
                    OP_REM_LINK:  n_state = f_hit ? S_FIND : S_DONE;
                    OP_QUERY:     n_state = S_QFRAME;
                    default:      n_state = S_DONE;
                endcase
            end
            S_FIND: begin
                if (find_match) begin
                    n_state = S_COMPACT;
                end else if (find_end) begin
                    n_state = (r_op == OP_ADD_LINK) ? S_ADD : S_DONE;
                end
            end
            S_COMPACT: begin
                if (cmp_end) begin
                    n_state = (r_op == OP_ADD_LINK) ? S_ADD : S_DONE;
                end
            end
            S_ADD:    n_state = S_DONE;
            S_QFRAME: n_state = q_more ? S_QDIV : S_QEND;
            S_QDIV: begin
                if (div_done) begin
                    n_state = S_QSCAN;
                end
            end
            S_QSCAN: begin
                if (qscan_end) begin
                    n_state = S_QFRAME;
                end
            end
            S_QEND: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory and unit controls
    always_comb begin
        seq_we    = 1'b0;
        seq_waddr = r_j[LW-1:0];
        seq_wdata = seq_q;
        seq_raddr = idx_i;
        lnk_we    = 1'b0;
        lnk_waddr = l_free;
        lnk_raddr = (r_state == S_QSCAN) ? seq_q : idx_i;
        lnk_wdata = '{slot: r_slot, chan: r_chan, id: r_next_id, opt: r_opt,
                      kind: r_kind, addr: r_addr};
        div_start = (r_state == S_QFRAME) && q_more;
        unique case (r_state)
            S_COMPACT: begin
                seq_we = cmp_keep;
            end
            S_ADD: begin
                seq_we    = l_free_ok;
                seq_waddr = r_lcount[LW-1:0];
                seq_wdata = l_free;
                lnk_we    = l_free_ok;
            end
            default: begin
                seq_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fcount  <= '0;
            r_lvalid  <= '0;
            r_lcount  <= '0;
            r_next_id <= '0;
            r_ovalid  <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_pv1     <= 1'b0;
            r_pv2     <= 1'b0;
            r_fi      <= '0;
            r_bfound  <= 1'b0;
            r_kfound  <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_fvalid[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            // The result is loaded on leaving the done state and cleared once taken
            if (r_state == S_DONE && out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_EXEC: begin
                    r_i   <= '0;
                    r_j   <= '0;
                    r_pv1 <= 1'b0;
                    r_pv2 <= 1'b0;
                    if (r_op == OP_ADD_FRAME && r_size != '0 && !f_hit && f_free_ok) begin
                        r_fvalid[f_free] <= 1'b1;
                        r_fcount         <= r_fcount + 1'b1;
                    end
                    if (r_op == OP_REM_FRAME && f_hit) begin
                        r_fvalid[f_idx] <= 1'b0;
                        r_fcount        <= fo_cnt;
                        for (int k = 0; k < MAX_LINKS; k++) begin
                            if (r_lframe[k] == f_idx) begin
                                r_lvalid[k] <= 1'b0;
                            end
                        end
                    end
                    if (r_op == OP_QUERY) begin
                        r_fi     <= '0;
                        r_bfound <= 1'b0;
                        r_kfound <= 1'b0;
                    end
                end
                S_FIND: begin
                    if (find_match) begin
                        r_lvalid[r_l2] <= 1'b0;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_pv1 <= 1'b0;
                    end else begin
                        r_pv1 <= issue_links && r_lvalid[idx_i] && r_lframe[idx_i] == r_fsel;
                        if (issue_links) begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_COMPACT: begin
                    if (cmp_end) begin
                        r_lcount <= r_j;
                    end else begin
                        r_pv1 <= issue_seq;
                        if (issue_seq) begin
                            r_i <= r_i + 1'b1;
                        end
                        if (cmp_keep) begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_ADD: begin
                    if (l_free_ok) begin
                        r_lvalid[l_free] <= 1'b1;
                        r_lcount         <= r_lcount + 1'b1;
                        r_next_id        <= r_next_id + 16'd1;
                    end
                end
                S_QDIV: begin
                    r_i   <= '0;
                    r_pv1 <= 1'b0;
                    r_pv2 <= 1'b0;
                end
                S_QSCAN: begin
                    if (qscan_end) begin
                        r_fi <= r_fi + 1'b1;
                    end else begin
                        r_pv1 <= issue_seq;
                        if (issue_seq) begin
                            r_i <= r_i + 1'b1;
                        end
                        r_pv2 <= r_pv1 && r_lvalid[seq_q] && r_lframe[seq_q] == r_cf;
                        if (r_pv2) begin
                            if (take_first) begin
                                r_bfound <= 1'b1;
                                r_kfound <= 1'b0;
                            end else if (tie && !r_kfound &&
                                         (r_bopt[1] || (!nb && l_q.opt[1]))) begin
                                r_kfound <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_pv2 <= r_pv2;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op     <= i_operation;
                    r_handle <= i_frame_handle;
                    r_size   <= i_frame_size;
                    r_opt    <= i_option_bits;
                    r_kind   <= i_kind;
                    r_addr   <= i_peer_address;
                    r_slot   <= i_slot_index;
                    r_chan   <= i_channel_shift;
                    r_asn    <= i_absolute_slot;
                    r_status <= ST_OK;
                    r_rid    <= '0;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ADD_FRAME: begin
                        if (r_size == '0) begin
                            r_status <= ST_BAD_SIZE;
                        end else if (f_hit) begin
                            r_status <= ST_DUPLICATE;
                        end else if (!f_free_ok) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_fhandle[f_free]            <= r_handle;
                            r_fsize[f_free]              <= r_size;
                            r_forder[r_fcount[FW-1:0]]   <= f_free;
                        end
                    end
                    OP_REM_FRAME: begin
                        if (f_hit) begin
                            for (int k = 0; k < MAX_FRAMES; k++) begin
                                r_forder[k] <= fo_new[k];
                            end
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                    OP_ADD_LINK,
                    OP_REM_LINK: begin
                        if (f_hit) begin
                            r_fsel <= f_idx;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                    OP_QUERY: begin
                        r_rid <= '0;
                    end
                    default: begin
                        r_status <= ST_NOT_FOUND;
                    end
                endcase
            end
            S_FIND: begin
                r_l2 <= idx_i;
                if (!find_match && find_end && r_op == OP_REM_LINK) begin
                    r_status <= ST_NOT_FOUND;
                end
            end
            S_ADD: begin
                if (l_free_ok) begin
                    r_lframe[l_free] <= r_fsel;
                    r_rid            <= r_next_id;
                end else begin
                    r_status <= ST_FULL;
                end
            end
            S_QFRAME: begin
                if (q_more) begin
                    r_cf <= r_forder[r_fi[FW-1:0]];
                end
            end
            S_QDIV: begin
                if (div_done) begin
                    r_now <= div_rem;
                end
            end
            S_QSCAN: begin
                if (r_pv2) begin
                    // The backup is chosen against the best as it stood
                    if (!take_first && tie && !r_kfound) begin
                        if (r_bopt[1]) begin
                            r_kid <= r_bid;
                        end else if (!nb && l_q.opt[1]) begin
                            r_kid <= l_q.id;
                        end
                    end
                    if (take_first || (tie && nb)) begin
                        r_bt    <= slot_gap;
                        r_bid   <= l_q.id;
                        r_bslot <= l_q.slot;
                        r_bchan <= l_q.chan;
                        r_bopt  <= l_q.opt;
                        r_bkind <= l_q.kind;
                        r_baddr <= l_q.addr;
                        r_bfh   <= r_fhandle[r_cf];
                    end
                end
            end
            S_QEND: begin
                if (r_bfound) begin
                    r_rid <= r_bid;
                end else begin
                    r_status <= ST_NOT_FOUND;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_ostatus <= r_status;
                    r_olink   <= r_rid;
                    if (r_op == OP_QUERY && r_bfound) begin
                        r_ountil  <= r_bt;
                        r_oframe  <= r_bfh;
                        r_oslot   <= r_bslot;
                        r_ochan   <= r_bchan;
                        r_oopt    <= r_bopt;
                        r_okind   <= r_bkind;
                        r_oaddr   <= r_baddr;
                        r_okfound <= r_kfound;
                        r_okid    <= r_kfound ? r_kid : '0;
                    end else begin
                        r_ountil  <= '0;
                        r_oframe  <= '0;
                        r_oslot   <= '0;
                        r_ochan   <= '0;
                        r_oopt    <= '0;
                        r_okind   <= '0;
                        r_oaddr   <= '0;
                        r_okfound <= 1'b0;
                        r_okid    <= '0;
                    end
                end
            end
            default: begin
                r_l2 <= r_l2;
            end
        endcase
    end

    // Link order memory
    tlst_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_LINKS)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (seq_we),
        .i_waddr (seq_waddr),
        .i_wdata (seq_wdata),
        .i_raddr (seq_raddr),
        .o_rdata (seq_q)
    );

    // Link record memory
    tlst_ram #(
        .WIDTH(LINK_W),
        .DEPTH(MAX_LINKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_rdata)
    );

    // Slot number modulo slotframe size
    tlst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_asn),
        .i_divisor  (r_fsize[r_forder[r_fi[FW-1:0]]]),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Ports
    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_link_id        = r_olink;
    assign o_slots_until    = r_ountil;
    assign o_chosen_frame   = r_oframe;
    assign o_chosen_slot    = r_oslot;
    assign o_chosen_channel = r_ochan;
    assign o_chosen_options = r_oopt;
    assign o_chosen_kind    = r_okind;
    assign o_chosen_address = r_oaddr;
    assign o_backup_found   = r_okfound;
    assign o_backup_id      = r_okid;

    // Checks
    a_link_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcount <= CW'(MAX_LINKS))
        else $error("link count beyond table size");

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcount <= FCW'(MAX_FRAMES))
        else $error("slotframe count beyond table size");

    a_valid_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_lvalid) == int'(r_lcount)))
        else $error("link order length differs from valid links");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted transfer not executed");

endmodule

// ----- bench/tsch_link_schedule_table_top_test.sv -----
// ----------------------------------------------------------------------------
// TSCH link schedule table: self-checking test
// Commands are driven through the valid/ready command channel with random
// gaps. A scoreboard model in this file predicts every response, and each
// response transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tsch_link_schedule_table_top_test
    import tlst_pkg::*;
();

    localparam int NLINK  = 32;
    localparam int NFRAME = 4;
    localparam int WATCHDOG_LIMIT = 200000;

    // Expected response record.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] link_id;
        logic [15:0] slots_until;
        logic [15:0] frame;
        logic [15:0] slot;
        logic [15:0] chan;
        logic [3:0]  opt;
        logic [1:0]  kind;
        logic [63:0] addr;
        logic        bk_found;
        logic [15:0] bk_id;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [15:0] i_frame_handle;
    logic [15:0] i_frame_size;
    logic [3:0]  i_option_bits;
    logic [1:0]  i_kind;
    logic [63:0] i_peer_address;
    logic [15:0] i_slot_index;
    logic [15:0] i_channel_shift;
    logic [39:0] i_absolute_slot;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [15:0] o_link_id;
    logic [15:0] o_slots_until;
    logic [15:0] o_chosen_frame;
    logic [15:0] o_chosen_slot;
    logic [15:0] o_chosen_channel;
    logic [3:0]  o_chosen_options;
    logic [1:0]  o_chosen_kind;
    logic [63:0] o_chosen_address;
    logic        o_backup_found;
    logic [15:0] o_backup_id;

    tsch_link_schedule_table_top i_dut (.*);

    // Model state of the schedule.
    bit          fr_used [NFRAME];
    logic [15:0] fr_hdl  [NFRAME];
    logic [15:0] fr_len  [NFRAME];
    int          fr_ord  [NFRAME];
    int          fr_num;
    bit          lk_used [NLINK];
    int          lk_fr   [NLINK];
    t_link       lk_rec  [NLINK];
    int          lk_ord  [NLINK];
    int          lk_num;
    logic [15:0] id_next;

    t_resp       pending_resp[$];
    int          err_count;
    int          idle_cycles;
    bit          stall_enable;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Random gap length: mostly short, occasionally long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int frame_lookup(logic [15:0] h);
        for (int i = 0; i < fr_num; i++)
            if (fr_used[fr_ord[i]] && fr_hdl[fr_ord[i]] == h) return fr_ord[i];
        return -1;
    endfunction

    function automatic void link_drop(int l);
        int j;
        j = 0;
        lk_used[l] = 1'b0;
        for (int i = 0; i < lk_num; i++)
            if (lk_ord[i] != l) begin
                lk_ord[j] = lk_ord[i];
                j++;
            end
        lk_num = j;
    endfunction

    function automatic int link_lookup(int f, logic [15:0] s, logic [15:0] c);
        for (int i = 0; i < lk_num; i++) begin
            int l;
            l = lk_ord[i];
            if (lk_used[l] && lk_fr[l] == f && lk_rec[l].slot == s && lk_rec[l].chan == c)
                return l;
        end
        return -1;
    endfunction

    // Predict the response of one command and update the schedule model.
    function automatic t_resp schedule_predict(logic [2:0] op, logic [15:0] h,
            logic [15:0] sz, logic [3:0] opt, logic [1:0] kd, logic [63:0] ad,
            logic [15:0] s, logic [15:0] c, logic [39:0] asn);
        t_resp r;
        int f, l, j, best, bk;
        logic [15:0] tb, now, t;
        r = '0;
        case (op)
            OP_ADD_FRAME: begin
                if (sz == 0) begin
                    r.status = ST_BAD_SIZE;
                end else if (frame_lookup(h) >= 0) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    f = 0;
                    while (f < NFRAME && fr_used[f]) f++;
                    if (f >= NFRAME || fr_num >= NFRAME) begin
                        r.status = ST_FULL;
                    end else begin
                        fr_used[f] = 1'b1;
                        fr_hdl[f] = h;
                        fr_len[f] = sz;
                        fr_ord[fr_num] = f;
                        fr_num++;
                    end
                end
            end
            OP_REM_FRAME: begin
                f = frame_lookup(h);
                if (f < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (l = 0; l < NLINK; l++)
                        if (lk_used[l] && lk_fr[l] == f) link_drop(l);
                    fr_used[f] = 1'b0;
                    j = 0;
                    for (int i = 0; i < fr_num; i++)
                        if (fr_ord[i] != f) begin
                            fr_ord[j] = fr_ord[i];
                            j++;
                        end
                    fr_num = j;
                end
            end
            OP_ADD_LINK: begin
                f = frame_lookup(h);
                if (f < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    l = link_lookup(f, s, c);
                    if (l >= 0) link_drop(l);
                    l = 0;
                    while (l < NLINK && lk_used[l]) l++;
                    if (l >= NLINK || lk_num >= NLINK) begin
                        r.status = ST_FULL;
                    end else begin
                        lk_used[l] = 1'b1;
                        lk_fr[l] = f;
                        lk_rec[l] = '{slot: s, chan: c, id: id_next, opt: opt,
                                      kind: kd, addr: ad};
                        id_next = id_next + 16'd1;
                        lk_ord[lk_num] = l;
                        lk_num++;
                        r.link_id = lk_rec[l].id;
                    end
                end
            end
            OP_REM_LINK: begin
                f = frame_lookup(h);
                l = (f < 0) ? -1 : link_lookup(f, s, c);
                if (l < 0) r.status = ST_NOT_FOUND;
                else link_drop(l);
            end
            OP_QUERY: begin
                best = -1;
                bk = -1;
                tb = '0;
                for (int fi = 0; fi < fr_num; fi++) begin
                    f = fr_ord[fi];
                    if (!fr_used[f] || fr_len[f] == 0) continue;
                    now = 16'(asn % 40'(fr_len[f]));
                    for (int li = 0; li < lk_num; li++) begin
                        int nb;
                        l = lk_ord[li];
                        if (!lk_used[l] || lk_fr[l] != f) continue;
                        if (lk_rec[l].slot > now) t = lk_rec[l].slot - now;
                        else t = fr_len[f] + lk_rec[l].slot - now;
                        if (best < 0 || t < tb) begin
                            tb = t;
                            best = l;
                            bk = -1;
                        end else if (t == tb && lk_rec[l].chan != lk_rec[best].chan) begin
                            nb = -1;
                            if (lk_rec[best].opt[0] == lk_rec[l].opt[0]) begin
                                if (fr_hdl[lk_fr[l]] < fr_hdl[lk_fr[best]]) nb = l;
                            end else if (lk_rec[l].opt[0]) begin
                                nb = l;
                            end
                            if (bk < 0) begin
                                if (nb != l && lk_rec[l].opt[1]) bk = l;
                                if (nb != best && lk_rec[best].opt[1]) bk = best;
                            end
                            if (nb >= 0) best = nb;
                        end
                    end
                end
                if (best < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.link_id = lk_rec[best].id;
                    r.slots_until = tb;
                    r.frame = fr_hdl[lk_fr[best]];
                    r.slot = lk_rec[best].slot;
                    r.chan = lk_rec[best].chan;
                    r.opt = lk_rec[best].opt;
                    r.kind = lk_rec[best].kind;
                    r.addr = lk_rec[best].addr;
                    if (bk >= 0) begin
                        r.bk_found = 1'b1;
                        r.bk_id = lk_rec[bk].id;
                    end
                end
            end
            default: r.status = ST_NOT_FOUND;
        endcase
        return r;
    endfunction

    // Send one command transfer and record its predicted response.
    task automatic send_command(logic [2:0] op, logic [15:0] h, logic [15:0] sz,
            logic [3:0] opt, logic [1:0] kd, logic [63:0] ad, logic [15:0] s,
            logic [15:0] c, logic [39:0] asn);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = op;
        i_frame_handle = h;
        i_frame_size = sz;
        i_option_bits = opt;
        i_kind = kd;
        i_peer_address = ad;
        i_slot_index = s;
        i_channel_shift = c;
        i_absolute_slot = asn;
        do @(posedge i_clk); while (!o_ready);
        pending_resp.push_back(schedule_predict(op, h, sz, opt, kd, ad, s, c, asn));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    // Response checker: compares every response transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_resp w;
        if (i_rst_n && o_valid && i_ready) begin
            idle_cycles <= 0;
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected response", 64'd0, 64'd0);
            end else begin
                w = pending_resp.pop_front();
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_link_id !== w.link_id) report_mismatch("link_id", o_link_id, w.link_id);
                if (o_slots_until !== w.slots_until)
                    report_mismatch("slots_until", o_slots_until, w.slots_until);
                if (o_chosen_frame !== w.frame)
                    report_mismatch("chosen_frame", o_chosen_frame, w.frame);
                if (o_chosen_slot !== w.slot)
                    report_mismatch("chosen_slot", o_chosen_slot, w.slot);
                if (o_chosen_channel !== w.chan)
                    report_mismatch("chosen_channel", o_chosen_channel, w.chan);
                if (o_chosen_options !== w.opt)
                    report_mismatch("chosen_options", o_chosen_options, w.opt);
                if (o_chosen_kind !== w.kind)
                    report_mismatch("chosen_kind", o_chosen_kind, w.kind);
                if (o_chosen_address !== w.addr)
                    report_mismatch("chosen_address", o_chosen_address, w.addr);
                if (o_backup_found !== w.bk_found)
                    report_mismatch("backup_found", o_backup_found, w.bk_found);
                if (o_backup_id !== w.bk_id)
                    report_mismatch("backup_id", o_backup_id, w.bk_id);
            end
        end else if (i_valid && o_ready) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side back-pressure, changed at the falling edge.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!stall_enable) i_ready = 1'b1;
            else if ($urandom_range(0, 3) == 0) begin
                i_ready = 1'b0;
                repeat (gap_len()) @(negedge i_clk);
                i_ready = 1'b1;
            end else i_ready = 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [39:0] rand_asn();
        return {8'($urandom()), $urandom()};
    endfunction

    // Slotframe operations with every error case.
    task automatic test_frames();
        send_command(OP_ADD_FRAME, 16'h0001, 16'h0000, 0, 0, 0, 0, 0, 0);
        send_command(OP_ADD_FRAME, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        send_command(OP_ADD_FRAME, 16'h0000, 16'd7, 0, 0, 0, 0, 0, 0);
        send_command(OP_ADD_FRAME, 16'hFFFF, 16'd1, 0, 0, 0, 0, 0, 0);
        send_command(OP_ADD_FRAME, 16'd5, 16'd10, 0, 0, 0, 0, 0, 0);
        send_command(OP_ADD_FRAME, 16'd6, 16'd10, 0, 0, 0, 0, 0, 0);
        send_command(OP_ADD_FRAME, 16'd9, 16'd10, 0, 0, 0, 0, 0, 0);
        send_command(OP_REM_FRAME, 16'd1234, 0, 0, 0, 0, 0, 0, 0);
        send_command(3'd5, 0, 0, 0, 0, 0, 0, 0, 0);
        send_command(3'd7, 16'hFFFF, 16'hFFFF, 4'hF, 2'd3, '1, '1, '1, '1);
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF);
    endtask

    // Link add, replace, tie-breaking and backup selection.
    task automatic test_links();
        send_command(OP_ADD_LINK, 16'd77, 0, 4'h1, 2'd0, 0, 0, 0, 0);
        send_command(OP_ADD_LINK, 16'hFFFF, 0, 4'h2, 2'd1, rand64(), 16'd0, 16'd3, 0);
        send_command(OP_ADD_LINK, 16'd5, 0, 4'h1, 2'd2, '1, 16'd4, 16'd1, 0);
        send_command(OP_ADD_LINK, 16'd6, 0, 4'h2, 2'd3, rand64(), 16'd4, 16'd2, 0);
        send_command(OP_ADD_LINK, 16'd5, 0, 4'hF, 2'd0, rand64(), 16'd4, 16'd1, 0);
        send_command(OP_ADD_LINK, 16'd9, 0, 4'h3, 2'd0, rand64(), 16'hFFFF, 16'hFFFF, 0);
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 40'd0);
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 40'd4);
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF);
        send_command(OP_REM_LINK, 16'd5, 0, 0, 0, 0, 16'd4, 16'd9, 0);
        send_command(OP_REM_LINK, 16'd5, 0, 0, 0, 0, 16'd4, 16'd1, 0);
        send_command(OP_REM_FRAME, 16'd6, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 40'd3);
    endtask

    // Fill the link table to provoke the full status, then clear it.
    task automatic test_full_table();
        for (int i = 0; i < NLINK + 2; i++)
            send_command(OP_ADD_LINK, 16'd5, 0, 4'($urandom()), 2'($urandom()),
                         rand64(), 16'(i), 16'd0, 0);
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, rand_asn());
        for (int i = 0; i < NFRAME; i++)
            send_command(OP_REM_FRAME, fr_hdl[fr_ord[0]], 0, 0, 0, 0, 0, 0, 0);
    endtask

    // Random traffic over a small pool of handles, timeslots and offsets.
    task automatic test_random(int n);
        logic [2:0] op;
        logic [15:0] h, s, c, sz;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) op = OP_ADD_FRAME;
            else if (r < 17) op = OP_REM_FRAME;
            else if (r < 55) op = OP_ADD_LINK;
            else if (r < 67) op = OP_REM_LINK;
            else if (r < 97) op = OP_QUERY;
            else op = 3'($urandom_range(5, 7));
            h = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
            sz = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 1)) :
                 (($urandom_range(0, 19) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 12)));
            s = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
            c = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
            send_command(op, h, sz, 4'($urandom()), 2'($urandom()), rand64(), s, c,
                         rand_asn());
        end
    endtask

    // Main sequence.
    initial begin
        err_count = 0;
        idle_cycles = 0;
        stall_enable = 1'b0;
        fr_num = 0;
        lk_num = 0;
        id_next = '0;
        for (int i = 0; i < NFRAME; i++) fr_used[i] = 1'b0;
        for (int i = 0; i < NLINK; i++) lk_used[i] = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = '0;
        i_frame_handle = '0;
        i_frame_size = '0;
        i_option_bits = '0;
        i_kind = '0;
        i_peer_address = '0;
        i_slot_index = '0;
        i_channel_shift = '0;
        i_absolute_slot = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_frames();
        test_links();
        stall_enable = 1'b1;
        test_full_table();
        test_random(800);
        stall_enable = 1'b0;
        test_random(200);
        stall_enable = 1'b1;
        test_random(600);
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (err_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
